// ----- rtl/core/tdpt_pkg.sv -----
// Package: shared types, codes and constants of the trial-division prime test.
`timescale 1ns / 1ps
`default_nettype none
package tdpt_pkg;

    localparam int CANDIDATE_WIDTH      = 32;
    localparam int OUT_TDATA_WIDTH      = 8;
    localparam int NUMBER_WIDTH_DEFAULT = 32;

    localparam int SMALLEST_PRIME  = 2;
    localparam int FIRST_ODD_PRIME = 3;
    localparam int DIVISOR_STRIDE  = 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCREEN,
        ST_DIVIDE,
        ST_CHECK,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic init_divisor;
        logic start_div;
        logic step_div;
        logic advance;
        logic set_verdict;
        logic verdict;
    } t_cmd;

    typedef struct packed {
        logic trivial;
        logic trivial_value;
        logic div_last;
        logic divisor_gt_quot;
        logic rem_zero;
    } t_status;

endpackage
`default_nettype wire

// ----- rtl/core/tdpt_ctrl.sv -----
// Controller: sequences screening, the divisor loop and result hand-off.
`timescale 1ns / 1ps
`default_nettype none
module tdpt_ctrl (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    input  wire                    i_out_free,
    input  wire tdpt_pkg::t_status i_status,
    output tdpt_pkg::t_cmd         o_cmd,
    output logic                   o_in_ready,
    output logic                   o_emit
);

    tdpt_pkg::t_state r_state;
    tdpt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tdpt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            tdpt_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = tdpt_pkg::ST_SCREEN;
                end
            end
            tdpt_pkg::ST_SCREEN: begin
                if (i_status.trivial) begin
                    n_state = tdpt_pkg::ST_FINISH;
                end else begin
                    n_state = tdpt_pkg::ST_DIVIDE;
                end
            end
            tdpt_pkg::ST_DIVIDE: begin
                if (i_status.div_last) begin
                    n_state = tdpt_pkg::ST_CHECK;
                end
            end
            tdpt_pkg::ST_CHECK: begin
                if (i_status.divisor_gt_quot || i_status.rem_zero) begin
                    n_state = tdpt_pkg::ST_FINISH;
                end else begin
                    n_state = tdpt_pkg::ST_DIVIDE;
                end
            end
            tdpt_pkg::ST_FINISH: begin
                if (i_out_free) begin
                    n_state = tdpt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tdpt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        o_emit     = 1'b0;
        case (r_state)
            tdpt_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            tdpt_pkg::ST_SCREEN: begin
                if (i_status.trivial) begin
                    o_cmd.set_verdict = 1'b1;
                    o_cmd.verdict     = i_status.trivial_value;
                end else begin
                    o_cmd.init_divisor = 1'b1;
                    o_cmd.start_div    = 1'b1;
                end
            end
            tdpt_pkg::ST_DIVIDE: begin
                o_cmd.step_div = 1'b1;
            end
            tdpt_pkg::ST_CHECK: begin
                if (i_status.divisor_gt_quot) begin
                    o_cmd.set_verdict = 1'b1;
                    o_cmd.verdict     = 1'b1;
                end else if (i_status.rem_zero) begin
                    o_cmd.set_verdict = 1'b1;
                    o_cmd.verdict     = 1'b0;
                end else begin
                    o_cmd.advance   = 1'b1;
                    o_cmd.start_div = 1'b1;
                end
            end
            tdpt_pkg::ST_FINISH: begin
                o_emit = i_out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/core/tdpt_dp.sv -----
// Datapath: candidate, divisor and a bit-serial restoring divider.
`timescale 1ns / 1ps
`default_nettype none
module tdpt_dp #(
    parameter int NUMBER_WIDTH = tdpt_pkg::NUMBER_WIDTH_DEFAULT
) (
    input  wire                                    i_clk,
    input  wire  [tdpt_pkg::CANDIDATE_WIDTH-1:0]   i_candidate,
    input  wire  tdpt_pkg::t_cmd                   i_cmd,
    output tdpt_pkg::t_status                      o_status,
    output logic                                   o_verdict
);

    localparam int W  = NUMBER_WIDTH;
    localparam int CW = $clog2(NUMBER_WIDTH);

    logic [W+tdpt_pkg::CANDIDATE_WIDTH-1:0] w_cand_ext;
    logic [W-1:0]  w_cand;
    logic [W:0]    w_rem_shift;
    logic [W:0]    w_diff;
    logic          w_ge;

    logic [W-1:0]  r_n;
    logic [W-1:0]  r_div;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_quot;
    logic [CW-1:0] r_count;
    logic          r_verdict;

    assign w_cand_ext  = {{W{1'b0}}, i_candidate};
    assign w_cand      = w_cand_ext[W-1:0];
    assign w_rem_shift = {r_rem, r_quot[W-1]};
    assign w_diff      = w_rem_shift - {1'b0, r_div};
    assign w_ge        = ~w_diff[W];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n <= w_cand;
        end
        if (i_cmd.init_divisor) begin
            r_div <= W'(tdpt_pkg::FIRST_ODD_PRIME);
        end else if (i_cmd.advance) begin
            r_div <= r_div + W'(tdpt_pkg::DIVISOR_STRIDE);
        end
        if (i_cmd.start_div) begin
            r_rem   <= '0;
            r_quot  <= r_n;
            r_count <= '0;
        end else if (i_cmd.step_div) begin
            r_rem   <= w_ge ? w_diff[W-1:0] : w_rem_shift[W-1:0];
            r_quot  <= {r_quot[W-2:0], w_ge};
            r_count <= r_count + CW'(1);
        end
        if (i_cmd.set_verdict) begin
            r_verdict <= i_cmd.verdict;
        end
    end

    assign o_status.trivial = (r_n <= W'(tdpt_pkg::FIRST_ODD_PRIME)) || !r_n[0];
    assign o_status.trivial_value = (r_n == W'(tdpt_pkg::SMALLEST_PRIME))
                                 || (r_n == W'(tdpt_pkg::FIRST_ODD_PRIME));
    assign o_status.div_last        = (r_count == CW'(NUMBER_WIDTH - 1));
    assign o_status.divisor_gt_quot = (r_div > r_quot);
    assign o_status.rem_zero        = (r_rem == '0);
    assign o_verdict                = r_verdict;

endmodule
`default_nettype wire

// ----- rtl/core/trial_division_prime_test.sv -----
// Top level: trial-division prime test with stream input and output.
// One candidate is tested at a time. Numbers up to 3 and even numbers are
// settled by the screening step alone. Otherwise the odd divisors 3, 5, 7,
// ... are tried while divisor <= candidate / divisor; each trial is a run of
// the bit-serial restoring divider over all NUMBER_WIDTH quotient bits and
// then a check. The result sits in an output register, and the next
// candidate is taken while it waits.
`timescale 1ns / 1ps
`default_nettype none
module trial_division_prime_test #(
    parameter int NUMBER_WIDTH = tdpt_pkg::NUMBER_WIDTH_DEFAULT
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire  [tdpt_pkg::CANDIDATE_WIDTH-1:0] s_axis_tdata,  // [31:0] candidate
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    output logic [tdpt_pkg::OUT_TDATA_WIDTH-1:0] m_axis_tdata   // [0] prime_flag, [7:1] zero
);

    tdpt_pkg::t_cmd    w_cmd;
    tdpt_pkg::t_status w_status;
    logic              w_emit;
    logic              w_verdict;
    logic              w_out_free;
    logic              r_out_valid;
    logic              r_prime_flag;

    assign w_out_free = !r_out_valid || m_axis_tready;

    tdpt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_out_free (w_out_free),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_in_ready (s_axis_tready),
        .o_emit     (w_emit)
    );

    tdpt_dp #(
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_candidate (s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_verdict   (w_verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_prime_flag <= w_verdict;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(tdpt_pkg::OUT_TDATA_WIDTH-1){1'b0}}, r_prime_flag};

endmodule
`default_nettype wire

// ----- rtl/core/tdpt_checker.sv -----
// Checker: port-level properties of the prime test, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module tdpt_checker (
    input wire                                 i_clk,
    input wire                                 i_rst_n,
    input wire                                 s_axis_tvalid,
    input wire                                 s_axis_tready,
    input wire                                 m_axis_tvalid,
    input wire                                 m_axis_tready,
    input wire [tdpt_pkg::OUT_TDATA_WIDTH-1:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output transaction dropped or changed while stalled");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[tdpt_pkg::OUT_TDATA_WIDTH-1:1] == '0)
        else $error("output padding bits not zero");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a candidate is in progress");

    a_result_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready)
        else $error("result presented without freeing the input");

endmodule

bind trial_division_prime_test tdpt_checker u_tdpt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
